// ----- rtl/core/rlc_pkg.sv -----
// types and constants shared by the region list coalescer
`default_nettype none

package rlc_pkg;

    localparam logic [1:0]  REQ_BEGIN  = 2'd0;
    localparam logic [1:0]  REQ_CONTIG = 2'd1;
    localparam logic [1:0]  REQ_VECTOR = 2'd2;
    localparam logic [1:0]  REQ_FINISH = 2'd3;

    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;
    localparam int unsigned OUT_CAP = 64;
    localparam int unsigned CFG_W   = 7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        nblocks;
        logic [15:0]        elem_size;
        logic [47:0]        base_addr;
        logic signed [47:0] rel_off;
        logic [31:0]        vec_count;
        logic [31:0]        blk_size;
        logic signed [47:0] stride;
    } t_req;

    typedef struct packed {
        logic [31:0] blocks_done;
        logic        stopped_full;
        logic [6:0]  entries_used;
        logic [47:0] entry_addr;
        logic [31:0] entry_len;
        logic        last;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CMUL,
        S_CPLACE,
        S_VCHK,
        S_VMUL,
        S_VDEC,
        S_VDIVA,
        S_VAVL,
        S_VKM,
        S_VDIVK,
        S_VKSEL,
        S_VMULG,
        S_VMULB,
        S_VRUN,
        S_VPLACE,
        S_RES,
        S_FRD,
        S_FOUT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/rlc_if.sv -----
// valid/ready channel interfaces for requests, results and configuration
`default_nettype none

interface rlc_req_if;
    import rlc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rlc_rsp_if;
    import rlc_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rlc_cfg_if;
    import rlc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/region_list_coalescer_top.sv -----
// region list coalescer: builds a coalesced address/length list under a small sequencer
// vector: blocks are placed one at a time; a run of whole blocks that keep extending the newest
//   entry is folded as a whole (up to two 32-step divisions on the shared divider, two multiplies)
// one request at a time; the next is taken while a result waits in the output register
// sync active-low reset: sequencer, entry count, output valid cleared, max_entries set to 64
`default_nettype none

module region_list_coalescer_top #(
    parameter int MAX_LIST = 64
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    rlc_req_if.sink   i_req,
    rlc_rsp_if.source o_rsp,
    rlc_cfg_if.sink   i_cfg
);
    import rlc_pkg::*;

    localparam int CW = $clog2(MAX_LIST + 1);
    localparam int AW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;

    // control state
    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt;
    logic [CFG_W-1:0] r_max;
    logic             r_ovalid;
    t_rsp             r_odata;

    // request and walk registers
    t_req        r_req;
    logic [47:0] r_start;
    logic [31:0] r_left;
    logic [31:0] r_rem;
    logic [31:0] r_nb;
    logic        r_whole;
    logic [47:0] r_sz;
    logic        r_usegrow;
    logic [31:0] r_avail;
    logic [31:0] r_k;
    logic [31:0] r_grow;
    logic [31:0] r_done;
    logic        r_full;
    logic [CW-1:0] r_fk;

    // cached newest entry
    logic [47:0] r_laddr;
    logic [31:0] r_llen;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] r_prod;

    // shared radix-2 divider
    logic [31:0] r_dq, r_dr, r_dd;
    logic [4:0]  r_dc;
    logic        div_ld;
    logic [31:0] div_a, div_b;
    logic [32:0] div_t;
    logic        div_ge;

    // list memories
    logic [47:0] r_mem_addr [MAX_LIST];
    logic [31:0] r_mem_len  [MAX_LIST];
    logic [47:0] r_rd_addr;
    logic [31:0] r_rd_len;
    logic        rd_en;
    logic        mem_we;
    logic [AW-1:0] mem_idx;
    logic [47:0] mem_waddr;
    logic [31:0] mem_wlen;

    // placement helpers
    logic [47:0] tail_end;
    logic        pl_match;
    logic        cnt_full;
    logic [47:0] pl_sz;
    logic [48:0] sum_len;
    logic [31:0] sat_sum;
    logic [31:0] sat_sz;
    logic        pl_new;
    logic [CW-1:0] cnt_m1;
    logic        case_a, case_b, v_run;
    logic        f_last;
    logic        out_free, out_ld;
    t_rsp        out_d;
    logic        req_xfer;

    assign req_xfer = i_req.valid && i_req.ready;
    assign cnt_m1   = r_cnt - CW'(1);
    assign tail_end = r_laddr + {16'b0, r_llen};
    assign pl_match = (r_cnt != '0) && (tail_end == r_start);
    // capacity is min(max_entries, MAX_LIST)
    assign cnt_full = (32'(r_cnt) >= 32'(r_max)) || (32'(r_cnt) >= 32'(MAX_LIST));
    assign pl_sz    = (r_state == S_CPLACE) ? r_prod[47:0] : r_sz;
    assign sum_len  = {17'b0, r_llen} + {1'b0, pl_sz};
    assign sat_sum  = (sum_len > {17'b0, LEN_MAX}) ? LEN_MAX : sum_len[31:0];
    assign sat_sz   = (pl_sz[47:32] != '0) ? LEN_MAX : pl_sz[31:0];
    assign pl_new   = !pl_match && !cnt_full;

    // run of whole blocks that keep coalescing onto the newest entry
    assign case_a = (r_prod[47:0] == r_req.stride);
    assign case_b = (r_llen == LEN_MAX) && (r_req.stride == '0);
    assign v_run  = r_whole && pl_match && (case_a || case_b);

    assign f_last = (32'(r_fk) + 32'd1 == 32'(r_cnt)) || (32'(r_fk) + 32'd1 == OUT_CAP);

    assign div_t  = {r_dr, r_dq[31]};
    assign div_ge = (div_t >= {1'b0, r_dd});

    assign out_free = !r_ovalid || o_rsp.ready;

    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    unique case (i_req.data.req_type)
                        REQ_BEGIN:  n_state = S_RES;
                        REQ_CONTIG: n_state = S_CMUL;
                        REQ_VECTOR: n_state = S_VCHK;
                        REQ_FINISH: n_state = (r_cnt == '0) ? S_RES : S_FRD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CMUL:   n_state = S_CPLACE;
            S_CPLACE: n_state = S_RES;
            S_VCHK:   n_state = (r_rem == '0 || r_left == '0) ? S_RES : S_VMUL;
            S_VMUL:   n_state = S_VDEC;
            S_VDEC: begin
                if (!v_run)
                    n_state = S_VPLACE;
                else if (r_req.blk_size != '0)
                    n_state = S_VDIVA;
                else
                    n_state = S_VKM;
            end
            S_VDIVA:  n_state = (r_dc == 5'd31) ? S_VAVL : S_VDIVA;
            S_VAVL:   n_state = S_VKM;
            S_VKM: begin
                if (r_usegrow && r_sz[47:32] == '0)
                    n_state = S_VDIVK;
                else
                    n_state = S_VMULG;
            end
            S_VDIVK:  n_state = (r_dc == 5'd31) ? S_VKSEL : S_VDIVK;
            S_VKSEL:  n_state = S_VMULG;
            S_VMULG:  n_state = (r_k == '0) ? S_VPLACE : S_VMULB;
            S_VMULB:  n_state = S_VRUN;
            S_VRUN:   n_state = S_VCHK;
            S_VPLACE: n_state = (!pl_match && cnt_full) ? S_RES : S_VCHK;
            S_RES:    n_state = out_free ? S_IDLE : S_RES;
            S_FRD:    n_state = S_FOUT;
            S_FOUT: begin
                if (out_free)
                    n_state = f_last ? S_IDLE : S_FRD;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        mul_a     = '0;
        mul_b     = '0;
        div_ld    = 1'b0;
        div_a     = '0;
        div_b     = '0;
        mem_we    = 1'b0;
        mem_idx   = r_cnt[AW-1:0];
        mem_waddr = r_start;
        mem_wlen  = sat_sz;
        rd_en     = 1'b0;
        out_ld    = 1'b0;
        out_d     = '0;
        unique case (r_state)
            S_CMUL: begin
                mul_a = r_req.nblocks;
                mul_b = {16'b0, r_req.elem_size};
            end
            S_VMUL: begin
                mul_a = r_nb;
                mul_b = {16'b0, r_req.elem_size};
            end
            S_VDEC: begin
                div_ld = v_run && (r_req.blk_size != '0);
                div_a  = r_left - 32'd1;
                div_b  = r_req.blk_size;
            end
            S_VKM: begin
                div_ld = r_usegrow && (r_sz[47:32] == '0);
                div_a  = LEN_MAX - r_llen;
                div_b  = r_sz[31:0];
            end
            S_VMULG: begin
                mul_a = r_k;
                mul_b = r_usegrow ? r_sz[31:0] : 32'd0;
            end
            S_VMULB: begin
                mul_a = r_k;
                mul_b = r_req.blk_size;
            end
            S_VRUN: begin
                mem_we    = 1'b1;
                mem_idx   = cnt_m1[AW-1:0];
                mem_waddr = r_laddr;
                mem_wlen  = r_llen + r_grow;
            end
            S_CPLACE, S_VPLACE: begin
                if (pl_match) begin
                    mem_we    = 1'b1;
                    mem_idx   = cnt_m1[AW-1:0];
                    mem_waddr = r_laddr;
                    mem_wlen  = sat_sum;
                end else if (!cnt_full) begin
                    mem_we = 1'b1;
                end
            end
            S_RES: begin
                out_ld             = out_free;
                out_d.blocks_done  = r_done;
                out_d.stopped_full = r_full;
                out_d.entries_used = 7'(r_cnt);
                out_d.last         = 1'b1;
            end
            S_FRD: rd_en = 1'b1;
            S_FOUT: begin
                out_ld             = out_free;
                out_d.entries_used = 7'(r_cnt);
                out_d.entry_addr   = r_rd_addr;
                out_d.entry_len    = r_rd_len;
                out_d.last         = f_last;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_max    <= CFG_W'(64);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready)
                r_max <= i_cfg.data;
            if (req_xfer && i_req.data.req_type == REQ_BEGIN)
                r_cnt <= '0;
            else if ((r_state == S_CPLACE || r_state == S_VPLACE) && pl_new)
                r_cnt <= r_cnt + CW'(1);
            if (out_ld)
                r_ovalid <= 1'b1;
            else if (o_rsp.ready)
                r_ovalid <= 1'b0;
        end
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // shared divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (div_ld) begin
            r_dq <= div_a;
            r_dr <= '0;
            r_dd <= div_b;
            r_dc <= '0;
        end else if (r_state == S_VDIVA || r_state == S_VDIVK) begin
            r_dq <= {r_dq[30:0], div_ge};
            r_dr <= div_ge ? 32'(div_t - {1'b0, r_dd}) : div_t[31:0];
            r_dc <= r_dc + 5'd1;
        end
    end

    // list memories
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_addr[mem_idx] <= mem_waddr;
            r_mem_len[mem_idx]  <= mem_wlen;
        end
        if (rd_en) begin
            r_rd_addr <= r_mem_addr[r_fk[AW-1:0]];
            r_rd_len  <= r_mem_len[r_fk[AW-1:0]];
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (out_ld)
            r_odata <= out_d;
        if (mem_we) begin
            r_laddr <= mem_waddr;
            r_llen  <= mem_wlen;
        end
        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    r_req   <= i_req.data;
                    r_start <= i_req.data.base_addr + i_req.data.rel_off;
                    r_left  <= i_req.data.nblocks;
                    r_rem   <= i_req.data.vec_count;
                    r_full  <= 1'b0;
                    r_done  <= '0;
                    r_fk    <= '0;
                end
            end
            S_CPLACE: begin
                r_full <= !pl_match && cnt_full;
                r_done <= (!pl_match && cnt_full) ? 32'd0 : r_req.nblocks;
            end
            S_VCHK: begin
                r_whole <= (r_left > r_req.blk_size);
                r_nb    <= (r_left > r_req.blk_size) ? r_req.blk_size : r_left;
                r_done  <= r_req.nblocks - r_left;
            end
            S_VDEC: begin
                r_sz      <= r_prod[47:0];
                r_usegrow <= case_a && (r_prod[47:0] != '0);
                r_avail   <= r_rem;
            end
            S_VAVL:  r_avail <= (r_dq < r_rem) ? r_dq : r_rem;
            S_VKM: begin
                if (!r_usegrow)
                    r_k <= r_avail;
                else
                    r_k <= '0;
            end
            S_VKSEL: r_k <= (r_dq < r_avail) ? r_dq : r_avail;
            S_VMULB: r_grow <= r_usegrow ? r_prod[31:0] : 32'd0;
            S_VRUN: begin
                r_start <= r_start + {16'b0, r_grow};
                r_left  <= r_left - r_prod[31:0];
                r_rem   <= r_rem - r_k;
            end
            S_VPLACE: begin
                if (!pl_match && cnt_full) begin
                    r_full <= 1'b1;
                    r_done <= r_req.nblocks - r_left;
                end else begin
                    r_left  <= r_left - r_nb;
                    r_start <= r_start + r_req.stride;
                    r_rem   <= r_rem - 32'd1;
                end
            end
            S_FOUT: begin
                if (out_free && !f_last)
                    r_fk <= r_fk + CW'(1);
            end
            default: ;
        endcase
    end

    // entry count stays within the list storage
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= 32'(MAX_LIST))
        else $error("entry count beyond list storage");

    // a request is never taken while another is in progress
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> !i_req.ready)
        else $error("request taken during work");

    // entry count moves only on begin or a placement step
    a_cnt_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cnt) |-> ($past(r_state) == S_IDLE || $past(r_state) == S_CPLACE ||
                             $past(r_state) == S_VPLACE))
        else $error("entry count changed outside placement");

    // a coalescing run never gives elements back
    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_VRUN |=> r_left <= $past(r_left))
        else $error("run increased remaining elements");

    // the result register is loaded only when free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ld |-> (!r_ovalid || o_rsp.ready))
        else $error("result overwritten");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking region list coalescer bench: directed, capacity, random, hold-off tests
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rlc_pkg::*;

    localparam int          LIST_DEPTH  = 64;
    localparam longint      CYCLE_LIMIT = 1000000;
    localparam int          SETTLE_CYC  = 120;
    localparam logic [63:0] ADDR_MASK   = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] LEN_SAT     = 64'hFFFF_FFFF;

    // outcome of placing one region in the list
    typedef enum int { PL_COALESCED, PL_NEW, PL_FULL } t_place;

    logic i_clk;
    logic i_rst_n;

    rlc_req_if req_ch();
    rlc_rsp_if rsp_ch();
    rlc_cfg_if cfg_ch();

    region_list_coalescer_top #(.MAX_LIST(LIST_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // predicted list state, kept alongside the block
    logic [6:0]  max_entries_q;
    int unsigned list_count;
    logic [63:0] list_addr [LIST_DEPTH];
    logic [63:0] list_len  [LIST_DEPTH];

    t_rsp        expected_rsp_q[$];
    int          error_count;
    int unsigned items_sent;
    int unsigned results_seen;
    longint      cycle_count;

    // idling knobs, read by the sender task and the receiver process
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned recv_hold_cycles;

    // ---------------------------------------------------------------
    // list predictor
    // ---------------------------------------------------------------

    function automatic int unsigned list_capacity();
        return (32'(max_entries_q) > LIST_DEPTH) ? LIST_DEPTH : 32'(max_entries_q);
    endfunction

    // does the newest entry end exactly at this address
    function automatic bit tail_ends_at(logic [63:0] addr);
        if (list_count == 0)
            return 1'b0;
        return ((list_addr[list_count-1] + list_len[list_count-1]) & ADDR_MASK) == addr;
    endfunction

    function automatic t_place place_region(logic [63:0] addr, logic [63:0] size);
        logic [63:0] grown;
        if (tail_ends_at(addr)) begin
            grown = list_len[list_count-1] + size;
            list_len[list_count-1] = (grown > LEN_SAT) ? LEN_SAT : grown;
            return PL_COALESCED;
        end
        if (list_count >= list_capacity())
            return PL_FULL;
        list_addr[list_count] = addr;
        list_len[list_count]  = (size > LEN_SAT) ? LEN_SAT : size;
        list_count++;
        return PL_NEW;
    endfunction

    function automatic t_rsp make_rsp(logic [63:0] done, bit full, logic [63:0] addr,
                                      logic [63:0] len, bit last);
        t_rsp r;
        r.blocks_done  = done[31:0];
        r.stopped_full = full;
        r.entries_used = list_count[6:0];
        r.entry_addr   = addr[47:0];
        r.entry_len    = len[31:0];
        r.last         = last;
        return r;
    endfunction

    // vector request: walk the strided blocks, folding runs that keep extending the tail
    function automatic void walk_vector(t_req r);
        logic [63:0] left, idx, start, cnt, blk, elem, strd;
        logic [63:0] nb, sz, len, avail, k, km, grow;
        bit whole, full, folded;
        int unsigned tail;
        left  = 64'(r.nblocks);
        idx   = 0;
        cnt   = 64'(r.vec_count);
        blk   = 64'(r.blk_size);
        elem  = 64'(r.elem_size);
        strd  = {16'd0, r.stride};
        start = ({16'd0, r.base_addr} + {16'd0, r.rel_off}) & ADDR_MASK;
        full  = 1'b0;
        while (idx < cnt && left > 0) begin
            whole  = left > blk;
            nb     = whole ? blk : left;
            sz     = nb * elem;
            folded = 1'b0;
            if (whole && tail_ends_at(start)) begin
                tail  = list_count - 1;
                len   = list_len[tail];
                avail = cnt - idx;
                k     = 0;
                grow  = 0;
                if (blk > 0 && (left - 1) / blk < avail)
                    avail = (left - 1) / blk;
                if ((sz & ADDR_MASK) == strd) begin
                    if (sz == 0) begin
                        k = avail;
                    end else begin
                        km   = (LEN_SAT - len) / sz;
                        k    = (km < avail) ? km : avail;
                        grow = k * sz;
                    end
                end else if (len == LEN_SAT && strd == 0) begin
                    k = avail;
                end
                if (k > 0) begin
                    list_len[tail] = len + grow;
                    left   = left - k * blk;
                    start  = (start + k * strd) & ADDR_MASK;
                    idx    = idx + k;
                    folded = 1'b1;
                end
            end
            if (!folded) begin
                if (place_region(start, sz) == PL_FULL) begin
                    full = 1'b1;
                    break;
                end
                left  = left - nb;
                start = (start + strd) & ADDR_MASK;
                idx++;
            end
        end
        expected_rsp_q.push_back(make_rsp(64'(r.nblocks) - left, full, 0, 0, 1'b1));
    endfunction

    function automatic void predict_request(t_req r);
        logic [63:0] start;
        int unsigned n;
        start = ({16'd0, r.base_addr} + {16'd0, r.rel_off}) & ADDR_MASK;
        case (r.req_type)
            REQ_BEGIN: begin
                list_count = 0;
                expected_rsp_q.push_back(make_rsp(0, 1'b0, 0, 0, 1'b1));
            end
            REQ_CONTIG: begin
                if (place_region(start, 64'(r.nblocks) * 64'(r.elem_size)) == PL_FULL)
                    expected_rsp_q.push_back(make_rsp(0, 1'b1, 0, 0, 1'b1));
                else
                    expected_rsp_q.push_back(make_rsp(64'(r.nblocks), 1'b0, 0, 0, 1'b1));
            end
            REQ_VECTOR: begin
                walk_vector(r);
            end
            default: begin
                n = (list_count > OUT_CAP) ? OUT_CAP : list_count;
                if (n == 0)
                    expected_rsp_q.push_back(make_rsp(0, 1'b0, 0, 0, 1'b1));
                for (int unsigned e = 0; e < n; e++)
                    expected_rsp_q.push_back(make_rsp(0, 1'b0, list_addr[e], list_len[e],
                                                      e + 1 == n));
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // result checker: compare every transfer with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            results_seen++;
            if (expected_rsp_q.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                error_count++;
            end else begin
                want = expected_rsp_q.pop_front();
                if (got.blocks_done !== want.blocks_done)
                    $display("%0t: blocks_done exp %0d got %0d", $realtime,
                             want.blocks_done, got.blocks_done);
                if (got.stopped_full !== want.stopped_full)
                    $display("%0t: stopped_full exp %0b got %0b", $realtime,
                             want.stopped_full, got.stopped_full);
                if (got.entries_used !== want.entries_used)
                    $display("%0t: entries_used exp %0d got %0d", $realtime,
                             want.entries_used, got.entries_used);
                if (got.entry_addr !== want.entry_addr)
                    $display("%0t: entry_addr exp %h got %h", $realtime,
                             want.entry_addr, got.entry_addr);
                if (got.entry_len !== want.entry_len)
                    $display("%0t: entry_len exp %h got %h", $realtime,
                             want.entry_len, got.entry_len);
                if (got.last !== want.last)
                    $display("%0t: last exp %0b got %0b", $realtime, want.last, got.last);
                if (got !== want)
                    error_count++;
            end
        end
    end

    // receiver: random stalls plus a counted long hold-off on request
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            recv_hold_cycles--;
        end else begin
            rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_rsp_q.size());
            $display("** region_list_coalescer_top: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_req mk_req(logic [1:0] kind, logic [31:0] nb, logic [15:0] es,
                                    logic [47:0] base, logic [47:0] off, logic [31:0] cnt,
                                    logic [31:0] blk, logic [47:0] strd);
        t_req r;
        r.req_type  = kind;
        r.nblocks   = nb;
        r.elem_size = es;
        r.base_addr = base;
        r.rel_off   = off;
        r.vec_count = cnt;
        r.blk_size  = blk;
        r.stride    = strd;
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // offer one request; valid stays up after the transfer until the next call or drain
    task automatic send_req(t_req r);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data  = r;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_request(r);
        items_sent++;
    endtask

    // wait for every predicted result, then let the sequencer settle
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        wait (expected_rsp_q.size() == 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_max_entries(logic [6:0] value);
        drain();
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        max_entries_q = value;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // extremes, each request type and the corner cases
    task automatic test_directed();
        logic [47:0] b;
        b = 48'h0000_1000_0000;
        send_req(mk_req(REQ_FINISH, 0, 1, 0, 0, 0, 0, 0));              // empty list
        send_req(mk_req(REQ_BEGIN, '1, '1, '1, '1, '1, '1, '1));
        send_req(mk_req(REQ_CONTIG, 0, 8, b, 0, 0, 0, 0));              // zero size
        send_req(mk_req(REQ_CONTIG, 4, 8, b, 0, 0, 0, 0));              // extends it
        send_req(mk_req(REQ_CONTIG, 2, 8, b, 48'd32, 0, 0, 0));
        send_req(mk_req(REQ_CONTIG, '1, '1, b, 48'd1000, 0, 0, 0));     // saturates
        send_req(mk_req(REQ_CONTIG, 3, 16, b, 48'd1000 + 48'hFFFF_FFFF, 0, 0, 0));
        send_req(mk_req(REQ_CONTIG, 5, 4, 48'hFFFF_FFFF_FFF0, 48'd8, 0, 0, 0)); // wraps
        send_req(mk_req(REQ_CONTIG, 5, 4, 48'hFFFF_FFFF_FFF0, -48'sd16, 0, 0, 0));
        // contiguous vector run folded into one entry
        send_req(mk_req(REQ_VECTOR, 1000, 4, b, 48'h10_0000, '1, 4, 16));
        send_req(mk_req(REQ_VECTOR, 1000, 4, b, 48'h10_0FA0, '1, 4, 16));
        // runs out of vector count, gapped stride, runs out of blocks on a partial last block
        send_req(mk_req(REQ_VECTOR, 100, 2, b, 48'h20_0000, 3, 2, 64));
        send_req(mk_req(REQ_VECTOR, 7, 2, b, 48'h30_0000, 10, 3, 100));
        send_req(mk_req(REQ_VECTOR, 9, 1, b, 48'h40_0000, 5, 2, -48'sd50)); // backward
        send_req(mk_req(REQ_VECTOR, 5, 1, b, 48'h50_0000, '1, 0, 0));       // empty blocks
        send_req(mk_req(REQ_VECTOR, 0, 1, b, 48'h60_0000, 4, 2, 8));        // nothing to do
        send_req(mk_req(REQ_FINISH, 0, 1, 0, 0, 0, 0, 0));
        send_req(mk_req(REQ_FINISH, 0, 1, 0, 0, 0, 0, 0));                 // list kept
        // fill all 64 entries with zero-length blocks, then emit them
        send_req(mk_req(REQ_BEGIN, 0, 1, 0, 0, 0, 0, 0));
        send_req(mk_req(REQ_VECTOR, 5, 1, b, 0, 100, 0, 16));
        send_req(mk_req(REQ_CONTIG, 1, 1, b, 48'h7000, 0, 0, 0));           // full
        send_req(mk_req(REQ_FINISH, 0, 1, 0, 0, 0, 0, 0));
    endtask

    // capacity extremes and capacity lowered below current use
    task automatic test_capacity();
        write_max_entries(7'd1);
        send_req(mk_req(REQ_BEGIN, 0, 1, 0, 0, 0, 0, 0));
        send_req(mk_req(REQ_CONTIG, 2, 4, 48'h100, 0, 0, 0, 0));
        send_req(mk_req(REQ_CONTIG, 2, 4, 48'h100, 48'd8, 0, 0, 0));
        send_req(mk_req(REQ_CONTIG, 2, 4, 48'h100, 48'd64, 0, 0, 0));
        send_req(mk_req(REQ_VECTOR, 8, 4, 48'h100, 48'd16, 4, 2, 32));
        send_req(mk_req(REQ_FINISH, 0, 1, 0, 0, 0, 0, 0));
        write_max_entries(7'd64);
        send_req(mk_req(REQ_BEGIN, 0, 1, 0, 0, 0, 0, 0));
        send_req(mk_req(REQ_VECTOR, 5, 8, 48'h4000, 0, 5, 1, 100));
        write_max_entries(7'd2);
        send_req(mk_req(REQ_CONTIG, 1, 8, 48'h8000, 0, 0, 0, 0));
        send_req(mk_req(REQ_CONTIG, 1, 8, 48'h4000, 48'd408, 0, 0, 0));
        send_req(mk_req(REQ_FINISH, 0, 1, 0, 0, 0, 0, 0));
    endtask

    // one random request, mostly continuing the tail so coalescing happens often
    function automatic t_req rand_request();
        t_req        r;
        logic [63:0] tail_end;
        int unsigned pick;
        pick = $urandom_range(99);
        r = mk_req(REQ_CONTIG, $urandom_range(40), 16'($urandom_range(1, 64)), rand48(),
                   48'($urandom_range(4096)), $urandom_range(12), $urandom_range(8), 0);
        if (pick < 8) begin
            // noise: every field at full width
            r = mk_req(2'($urandom()), $urandom(), 16'($urandom()), rand48(), rand48(),
                       $urandom(), $urandom(), rand48());
            if (r.elem_size == 0)
                r.elem_size = 1;
            if (r.req_type == REQ_VECTOR && r.vec_count[31:7] != 0 && $urandom_range(1))
                r.vec_count = 32'(r.vec_count[6:0]);
            return r;
        end
        if (pick < 14)
            r.req_type = REQ_BEGIN;
        else if (pick < 22)
            r.req_type = REQ_FINISH;
        else if (pick < 60)
            r.req_type = REQ_VECTOR;
        if ($urandom_range(99) < 5)
            r.nblocks = $urandom();
        if (r.req_type == REQ_VECTOR) begin
            case ($urandom_range(3))
                0: r.stride = 48'(r.blk_size) * 48'(r.elem_size);        // contiguous
                1: r.stride = 48'(r.blk_size) * 48'(r.elem_size) +
                              48'($urandom_range(1, 64));
                2: r.stride = -48'sd1 * 48'($urandom_range(1, 512));
                default: r.stride = rand48();
            endcase
            if ($urandom_range(9) == 0)
                r.vec_count = $urandom();
        end
        if (list_count > 0 && $urandom_range(99) < 60) begin
            tail_end = (list_addr[list_count-1] + list_len[list_count-1]) & ADDR_MASK;
            r.rel_off = tail_end[47:0] - r.base_addr;
        end
        return r;
    endfunction

    task automatic test_random(int unsigned idle_pct, int unsigned stall_pct, int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_max_entries(7'($urandom_range(1, 64)));
        send_req(mk_req(REQ_BEGIN, 0, 1, 0, 0, 0, 0, 0));
        repeat (n) send_req(rand_request());
        send_req(mk_req(REQ_FINISH, 0, 1, 0, 0, 0, 0, 0));
    endtask

    // long receiver hold-off while requests keep coming, then a full pause
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_max_entries(7'd64);
        recv_hold_cycles = 400;
        send_req(mk_req(REQ_BEGIN, 0, 1, 0, 0, 0, 0, 0));
        repeat (6) begin
            send_req(mk_req(REQ_CONTIG, 1, 4, 48'h9000, 48'(16 * $urandom_range(40)),
                            0, 0, 0));
            send_req(mk_req(REQ_FINISH, 0, 1, 0, 0, 0, 0, 0));
        end
        drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.data      = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        rsp_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 0;
        error_count      = 0;
        items_sent       = 0;
        results_seen     = 0;
        cycle_count      = 0;
        max_entries_q    = 7'd64;
        list_count       = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_capacity();
        test_random(0, 0, 38);
        test_random(61, 0, 38);
        test_random(0, 61, 38);
        test_random(10, 10, 38);
        test_backpressure();
        write_max_entries(7'd64);

        $display("covered begin/contig/vector/finish, coalescing, saturation, full list,");
        $display("capacity 1..64, stalls and hold-off: %0d requests, %0d results",
                 items_sent, results_seen);
        if (error_count == 0 && expected_rsp_q.size() == 0) begin
            $display("** region_list_coalescer_top: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     expected_rsp_q.size());
            $display("** region_list_coalescer_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/rlc_pkg.sv
rtl/core/rlc_if.sv
rtl/core/region_list_coalescer_top.sv
tb/testbench.sv
